// File: src/wfd_pkg.sv
// Shared types and constants for the weather frame decoder.
// No dependencies; used by every module under src.
package wfd_pkg;

    localparam int FRAME_BITS  = 120;
    localparam int FRAME_BYTES = FRAME_BITS / 8;
    localparam int SUM_BYTES   = 13;
    localparam int STORE_DEPTH = 14;
    localparam int HDR_BYTES   = 3;
    localparam int CNT_W       = 5;
    localparam logic [CNT_W-1:0] COUNT_SAT = 5'd16;
    localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CSUM_IDX  = CNT_W'(STORE_DEPTH - 1);

    localparam logic [7:0] HDR_BYTE0 = 8'h55;
    localparam logic [7:0] HDR_BYTE1 = 8'h5a;
    localparam logic [7:0] HDR_BYTE2 = 8'h7c;

    localparam int OUT_DATA_W = 80;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LEN_FAIL = 2'd1,
        ST_HDR_FAIL = 2'd2,
        ST_SUM_FAIL = 2'd3
    } t_status;

    // One classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]       inv_byte;
        logic [CNT_W-1:0] idx;
        logic             hdr_ok;
        logic             last;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef struct packed {
        logic [31:0]       date_time_packed;
        logic [3:0]        wind_direction;
        logic [7:0]        wind_speed_raw;
        logic [7:0]        humidity_raw;
        logic signed [11:0] temperature_tenths;
        logic              battery_good;
        logic [2:0]        channel_number;
        logic [7:0]        station_id;
        t_status           status;
    } t_result;

    function automatic logic [7:0] hdr_byte(input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            2'd0:    b = HDR_BYTE0;
            2'd1:    b = HDR_BYTE1;
            2'd2:    b = HDR_BYTE2;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/weather_frame_decoder_top.sv
// Top level of the weather frame decoder: front, queue and back wired to streams.
// Depends on wfd_pkg, wfd_front, wfd_fifo and wfd_back.
//
// Feed one raw frame byte per beat on s_axis; tuser marks the first byte of a
// frame and tlast the last. The block takes one byte every cycle while the
// queue has room. An accepted byte is written into the front-to-back queue;
// from the head of that queue an end byte is decoded straight into the output
// register, which makes the result beat valid on m_axis. Only end bytes wait
// on m_axis_tready. The queue of FIFO_DEPTH entries lets the input keep
// flowing while a result is still waiting to be taken; the input stalls only
// once that queue is full.
module weather_frame_decoder_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [9:2] station_id, [12:10] channel_number,
    // [13] battery_good, [25:14] temperature_tenths, [33:26] humidity_raw,
    // [41:34] wind_speed_raw, [45:42] wind_direction,
    // [77:46] date_time_packed, [79:78] zero
    output logic [wfd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic             push, pop, space, q_valid;
    wfd_pkg::t_item   front_item, back_item;
    wfd_pkg::t_result res;

    assign s_axis_tready = space;

    wfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_raw   (s_axis_tdata),
        .i_start (s_axis_tuser),
        .i_end   (s_axis_tlast),
        .i_space (space),
        .o_push  (push),
        .o_item  (front_item)
    );

    wfd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_space (space),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (back_item)
    );

    wfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (back_item),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {(wfd_pkg::OUT_DATA_W - $bits(wfd_pkg::t_result))'(0), res};

endmodule

// File: src/wfd_front.sv
// Front end: takes raw bytes, tracks position and header match, inverts.
// Depends on wfd_pkg; feeds wfd_fifo.
module wfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_raw,
    input  logic           i_start,
    input  logic           i_end,
    input  logic           i_space,
    output logic           o_push,
    output wfd_pkg::t_item o_item
);

    logic [wfd_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_hdr_ok, n_hdr_ok;
    logic [wfd_pkg::CNT_W-1:0] idx;
    logic                      hdr_in;
    logic                      hdr_mismatch;

    assign o_push = i_valid && i_space;

    always_comb begin
        // A start mark drops whatever frame was in progress.
        idx          = i_start ? '0 : r_count;
        hdr_in       = i_start ? 1'b1 : r_hdr_ok;
        hdr_mismatch = (idx < wfd_pkg::CNT_W'(wfd_pkg::HDR_BYTES)) &&
                       (i_raw != wfd_pkg::hdr_byte(idx[1:0]));
        o_item.inv_byte = ~i_raw;
        o_item.idx      = idx;
        o_item.hdr_ok   = hdr_in && !hdr_mismatch;
        o_item.last     = i_end;
    end

    always_comb begin
        n_count  = r_count;
        n_hdr_ok = r_hdr_ok;
        if (o_push) begin
            if (i_end) begin
                n_count  = '0;
                n_hdr_ok = 1'b1;
            end else begin
                n_count  = (idx < wfd_pkg::COUNT_SAT) ? idx + 1'b1 : idx;
                n_hdr_ok = o_item.hdr_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hdr_ok <= 1'b1;
        end else begin
            r_count  <= n_count;
            r_hdr_ok <= n_hdr_ok;
        end
    end

endmodule

// File: src/wfd_fifo.sv
// Short queue between the front and the back of the frame decoder.
// Depends on wfd_pkg for the item type.
module wfd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wfd_pkg::t_item i_item,
    output logic           o_space,
    input  logic           i_pop,
    output logic           o_valid,
    output wfd_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wfd_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_used, n_used;
    logic             do_push, do_pop;

    assign o_space = (r_used != CNT_W'(DEPTH));
    assign o_valid = (r_used != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_used   = r_used;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_used = r_used + 1'b1;
        end else if (do_pop && !do_push) begin
            n_used = r_used - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_used   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_used   <= n_used;
        end
    end

endmodule

// File: src/wfd_back.sv
// Back end: stores inverted bytes, keeps the checksum, builds the result.
// Depends on wfd_pkg; drains wfd_fifo and owns the output register.
module wfd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  wfd_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output wfd_pkg::t_result o_res
);

    logic [7:0]       r_store [wfd_pkg::STORE_DEPTH];
    logic [7:0]       r_sum, n_sum;
    logic             r_res_valid, n_res_valid;
    wfd_pkg::t_result r_res, n_res;
    wfd_pkg::t_status status;
    logic             slot_free;
    logic [31:0]      dt;

    assign slot_free   = !r_res_valid || i_res_ready;
    // Only an end byte needs the output slot; other bytes always drain.
    assign o_pop       = i_valid && (!i_item.last || slot_free);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_sum = r_sum;
        if (o_pop && (i_item.idx < wfd_pkg::CNT_W'(wfd_pkg::SUM_BYTES))) begin
            n_sum = (i_item.idx == '0) ? i_item.inv_byte : r_sum + i_item.inv_byte;
        end
    end

    always_comb begin
        if (i_item.idx != wfd_pkg::LAST_IDX) begin
            status = wfd_pkg::ST_LEN_FAIL;
        end else if (!i_item.hdr_ok) begin
            status = wfd_pkg::ST_HDR_FAIL;
        end else if (r_sum != r_store[wfd_pkg::STORE_DEPTH-1]) begin
            status = wfd_pkg::ST_SUM_FAIL;
        end else begin
            status = wfd_pkg::ST_OK;
        end
        dt = {r_store[4][5:0], r_store[5], r_store[6], r_store[7], r_store[8][7:6]};
    end

    always_comb begin
        n_res       = r_res;
        n_res_valid = r_res_valid;
        if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
        if (o_pop && i_item.last) begin
            n_res_valid = 1'b1;
            n_res       = '0;
            n_res.status = status;
            if (status == wfd_pkg::ST_OK) begin
                n_res.station_id         = r_store[3];
                n_res.channel_number     = {1'b0, r_store[8][5:4]} + 3'd1;
                n_res.battery_good       = r_store[12][2];
                n_res.temperature_tenths = {r_store[8][3:0], r_store[9]};
                n_res.humidity_raw       = r_store[10];
                n_res.wind_speed_raw     = r_store[11];
                n_res.wind_direction     = r_store[12][7:4];
                n_res.date_time_packed   = dt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_item.idx < wfd_pkg::CNT_W'(wfd_pkg::STORE_DEPTH))) begin
            r_store[i_item.idx[3:0]] <= i_item.inv_byte;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_res_valid <= n_res_valid;
        end
    end

endmodule
